// File: sv/mequad_pkg.sv
package mequad_pkg;

    localparam int ENCODER_COUNT = 16;
    localparam int COUNT_BITS    = 8;
    localparam int SLOT_COUNT    = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // nibble slot (position * 2 + half) to encoder number
    localparam logic [3:0] ENC_MAP [SLOT_COUNT] = '{
        4'd14, 4'd15, 4'd10, 4'd11, 4'd6, 4'd7, 4'd2, 4'd3,
        4'd12, 4'd13, 4'd8,  4'd9,  4'd4, 4'd5, 4'd0, 4'd1
    };

    typedef struct packed {
        logic [7:0] raw_byte;
        logic [2:0] byte_position;
    } item_t;

    typedef struct packed {
        logic [3:0] encoder_number;
        logic [1:0] button_level;
        logic       button_event;
        logic       rotation_event;
        logic [7:0] rotation_count;
        logic       last_of_run;
    } result_t;

    // count action of one nibble; STEP_BOTH is down then up, net zero
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN,
        STEP_BOTH
    } step_t;

    typedef struct packed {
        logic       hit;
        logic       button_event;
        logic [1:0] button_level;
        step_t      step;
    } half_op_t;

    typedef struct packed {
        logic [2:0]     byte_position;
        half_op_t [1:0] halves;
    } work_t;

endpackage

// File: sv/multi_encoder_quadrature_scanner.sv
// Each accepted byte with a reporting nibble is queued; the back end registers
// one result per reporting nibble; a second follows once the first is taken.
// Throughput: one byte per cycle into a four-entry queue while it is not full;
// the back end sends one result per cycle unless result_stall holds it.
// Reset (rst_n low, asynchronous): stored nibbles, counts and queue clear to zero.
module multi_encoder_quadrature_scanner
    import mequad_pkg::*;
#(
    parameter int COUNT_BITS_P = COUNT_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    work_t q_in;
    work_t q_out;

    mequad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    mequad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    mequad_back #(
        .COUNT_BITS_P (COUNT_BITS_P)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // every result reports some change
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.button_event || result.rotation_event))
        else $error("result without any event");

    // first of a pair is the low nibble; its partner follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_of_run) |=>
            (result_valid && result.last_of_run &&
             result.encoder_number == 4'($past(result.encoder_number) + 4'd1)))
        else $error("second result of a byte missing or misordered");

    // a full queue stays full until an entry is popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> q_full)
        else $error("queue lost an entry while full");

endmodule

// File: sv/mequad_front.sv
module mequad_front
    import mequad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  q_full,
    output logic  q_push,
    output work_t q_data
);

    // last byte seen at each frame position, i.e. last nibble of each slot
    logic [7:0] last_reg [8];

    logic     accept;
    logic [7:0] old_byte;
    half_op_t op0;
    half_op_t op1;

    function automatic half_op_t classify(input logic [3:0] old_nib,
                                          input logic [3:0] new_nib,
                                          input logic [3:0] slot);
        half_op_t   r;
        logic [3:0] o;
        logic [3:0] n;
        logic       enc_ok;
        logic       edge_a;
        logic       edge_b;
        logic       both_hi;
        o       = old_nib & NIBBLE_MASK;
        n       = new_nib & NIBBLE_MASK;
        enc_ok  = (32'(ENC_MAP[slot]) < ENCODER_COUNT);
        edge_a  = n[1] != o[1];
        edge_b  = n[0] != o[0];
        both_hi = n[1] & n[0];
        r.button_level = n[3:2];
        r.button_event = n[3:2] != o[3:2];
        // A edge into A=B=1 steps down, B edge into A=B=1 steps up, both at once is STEP_BOTH
        if (both_hi && edge_a && edge_b)
            r.step = STEP_BOTH;
        else if (both_hi && edge_a)
            r.step = STEP_DOWN;
        else if (both_hi && edge_b)
            r.step = STEP_UP;
        else
            r.step = STEP_NONE;
        r.hit = (o != n) && enc_ok && (r.button_event || (r.step != STEP_NONE));
        return r;
    endfunction

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign old_byte   = last_reg[item.byte_position];

    assign op0 = classify(old_byte[3:0], item.raw_byte[3:0], {item.byte_position, 1'b0});
    assign op1 = classify(old_byte[7:4], item.raw_byte[7:4], {item.byte_position, 1'b1});

    assign q_push = accept && (op0.hit || op1.hit);
    assign q_data = work_t'{byte_position: item.byte_position, halves: {op1, op0}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            last_reg[item.byte_position] <= item.raw_byte;
        end
    end

endmodule

// File: sv/mequad_queue.sv
module mequad_queue
    import mequad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t pop_data,
    output logic  empty
);

    work_t                    mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg;
    logic [FIFO_PTR_BITS:0]   count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full     = count_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/mequad_back.sv
module mequad_back
    import mequad_pkg::*;
#(
    parameter int COUNT_BITS_P = COUNT_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  work_t   q_data,
    output logic    q_pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic [COUNT_BITS_P-1:0] count_reg [SLOT_COUNT];
    logic [COUNT_BITS_P-1:0] count_now;
    logic [COUNT_BITS_P-1:0] count_next;
    logic                    half_reg;
    logic                    half_next;
    logic                    result_valid_reg;
    result_t                 result_reg;
    result_t                 result_next;

    logic       adv;
    logic       sel;
    logic       more;
    logic [3:0] slot;
    half_op_t   op;

    // low half first unless it has no result or was already sent
    assign sel  = half_reg || !q_data.halves[0].hit;
    assign op   = q_data.halves[sel];
    assign slot = {q_data.byte_position, sel};
    assign more = !sel && q_data.halves[1].hit;
    assign adv  = !q_empty && (!result_valid_reg || !result_stall);

    assign q_pop     = adv && !more;
    assign half_next = more;
    assign count_now = count_reg[slot];

    always_comb
    begin
        case (op.step)
            STEP_UP:   count_next = count_now + 1'b1;
            STEP_DOWN: count_next = count_now - 1'b1;
            default:   count_next = count_now;
        endcase
    end

    always_comb
    begin
        result_next.encoder_number = ENC_MAP[slot];
        result_next.button_level   = op.button_level;
        result_next.button_event   = op.button_event;
        result_next.rotation_event = op.step != STEP_NONE;
        result_next.rotation_count = 8'(count_next);
        result_next.last_of_run    = !more;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
            half_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            count_reg[slot]  <= count_next;
            half_reg         <= half_next;
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: bench/tb_multi_encoder_quadrature_scanner.sv
`timescale 1ns / 1ps

module tb_multi_encoder_quadrature_scanner;
    import mequad_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PRINT_LIMIT    = 40;

    // nibble slot to encoder
    localparam logic [3:0] SLOT_ENCODER [16] = '{
        4'd14, 4'd15, 4'd10, 4'd11, 4'd6, 4'd7, 4'd2, 4'd3,
        4'd12, 4'd13, 4'd8,  4'd9,  4'd4, 4'd5, 4'd0, 4'd1
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    item_stall;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // encoder state as the scanner should hold it
    logic [3:0] seen_nibble [16]            = '{default: '0};
    logic [1:0] button_q    [ENCODER_COUNT] = '{default: '0};
    logic       phase_a_q   [ENCODER_COUNT] = '{default: '0};
    logic       phase_b_q   [ENCODER_COUNT] = '{default: '0};
    logic       up_q        [ENCODER_COUNT] = '{default: '0};
    logic [7:0] count_q     [ENCODER_COUNT] = '{default: '0};

    result_t encoder_reports [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;

    // stimulus side: last nibble sent per slot and intended turn direction
    logic [3:0] scan_nibble [16] = '{default: '0};
    logic       scan_up     [16] = '{default: '0};

    bit idle_on       = 1'b1;
    int long_hold_req = 0;
    int hold_left     = 0;
    int stall_left    = 0;

    always #5 clk = ~clk;

    multi_encoder_quadrature_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    function automatic void step_count(int enc);
        count_q[enc] = up_q[enc] ? count_q[enc] + 8'd1 : count_q[enc] - 8'd1;
    endfunction

    task automatic decode_scan_byte(input item_t it);
        result_t    reps [$];
        result_t    r;
        logic [3:0] slot;
        logic [3:0] nib;
        logic [1:0] btn;
        logic       a;
        logic       b;
        logic       bev;
        logic       rev;
        int         enc;
        for (int half = 0; half < 2; half++)
        begin
            slot = {it.byte_position, half[0]};
            nib  = it.raw_byte[half*4 +: 4];
            if (nib == seen_nibble[slot])
                continue;
            seen_nibble[slot] = nib;
            enc = int'(SLOT_ENCODER[slot]);
            if (enc >= ENCODER_COUNT)
                continue;
            btn = nib[3:2];
            a   = nib[1];
            b   = nib[0];
            bev = 1'b0;
            rev = 1'b0;
            if (btn != button_q[enc])
            begin
                button_q[enc] = btn;
                bev = 1'b1;
            end
            // A is handled before B when both move in one sample
            if (a != phase_a_q[enc])
            begin
                phase_a_q[enc] = a;
                up_q[enc] = b ? ~a : a;
                if (a && b)
                begin
                    step_count(enc);
                    rev = 1'b1;
                end
            end
            if (b != phase_b_q[enc])
            begin
                phase_b_q[enc] = b;
                up_q[enc] = a ? b : ~b;
                if (a && b)
                begin
                    step_count(enc);
                    rev = 1'b1;
                end
            end
            if (bev || rev)
            begin
                r.encoder_number = enc[3:0];
                r.button_level   = button_q[enc];
                r.button_event   = bev;
                r.rotation_event = rev;
                r.rotation_count = count_q[enc];
                r.last_of_run    = 1'b0;
                reps.push_back(r);
            end
        end
        if (reps.size() > 0)
            reps[reps.size() - 1].last_of_run = 1'b1;
        foreach (reps[i])
            encoder_reports.push_back(reps[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_report(input result_t got);
        result_t want;
        if (encoder_reports.size() == 0)
        begin
            report_mismatch("result with nothing pending, encoder",
                            int'(got.encoder_number), -1);
            return;
        end
        want = encoder_reports.pop_front();
        if (got.encoder_number !== want.encoder_number)
            report_mismatch("encoder_number", int'(got.encoder_number),
                            int'(want.encoder_number));
        if (got.button_level !== want.button_level)
            report_mismatch("button_level", int'(got.button_level),
                            int'(want.button_level));
        if (got.button_event !== want.button_event)
            report_mismatch("button_event", int'(got.button_event),
                            int'(want.button_event));
        if (got.rotation_event !== want.rotation_event)
            report_mismatch("rotation_event", int'(got.rotation_event),
                            int'(want.rotation_event));
        if (got.rotation_count !== want.rotation_count)
            report_mismatch("rotation_count", int'(got.rotation_count),
                            int'(want.rotation_count));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", int'(got.last_of_run),
                            int'(want.last_of_run));
    endtask

    // monitor, checker and watchdog share one edge-sampled process
    always @(posedge clk)
    begin
        if (item_valid && !item_stall)
            decode_scan_byte(item);
        if (result_valid === 1'b1 && !result_stall)
            check_report(result);
        if ((item_valid && !item_stall) || (result_valid === 1'b1 && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 99) >= 30)
            return 0;
        return pick_len();
    endfunction

    // result side back-pressure; a long hold request overrides everything
    always @(posedge clk)
    begin
        if (long_hold_req > 0)
        begin
            hold_left = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!idle_on)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if ($urandom_range(0, 99) < 25)
                stall_left = pick_len();
        end
    end

    // one request; returns at the edge where it is taken
    task automatic send_scan_byte(input logic [2:0] pos, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{raw_byte: data, byte_position: pos};
        scan_nibble[{pos, 1'b0}] = data[3:0];
        scan_nibble[{pos, 1'b1}] = data[7:4];
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // the edge that took the last request may not be decoded yet
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (encoder_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] next_nibble(int slot);
        logic [3:0] cur;
        logic [1:0] ab;
        int         r;
        cur = scan_nibble[slot];
        ab  = cur[1:0];
        r   = $urandom_range(0, 99);
        if ($urandom_range(0, 31) == 0)
            scan_up[slot] = ~scan_up[slot];
        if (r < 65)
        begin
            // one gray-code step in the chosen direction
            if (scan_up[slot])
                case (ab)
                    2'b00:   ab = 2'b10;
                    2'b10:   ab = 2'b11;
                    2'b11:   ab = 2'b01;
                    default: ab = 2'b00;
                endcase
            else
                case (ab)
                    2'b00:   ab = 2'b01;
                    2'b01:   ab = 2'b11;
                    2'b11:   ab = 2'b10;
                    default: ab = 2'b00;
                endcase
            cur[1:0] = ab;
        end
        else if (r < 77)
            cur[3:2] = 2'($urandom_range(0, 3));
        else if (r >= 87)
            cur = 4'($urandom_range(0, 15));
        return cur;
    endfunction

    task automatic test_idle_nibbles();
        send_scan_byte(3'd0, 8'h00);
        send_scan_byte(3'd7, 8'h00);
    endtask

    task automatic test_button_changes();
        send_scan_byte(3'd1, 8'hC4);
        send_scan_byte(3'd1, 8'h0C);
        send_scan_byte(3'd1, 8'h00);
    endtask

    task automatic test_rotation();
        // down from zero wraps, then back up
        send_scan_byte(3'd2, 8'h01);
        send_scan_byte(3'd2, 8'h03);
        send_scan_byte(3'd2, 8'h02);
        send_scan_byte(3'd2, 8'h00);
        send_scan_byte(3'd2, 8'h02);
        send_scan_byte(3'd2, 8'h03);
        // both nibbles step in the same byte
        send_scan_byte(3'd3, 8'h22);
        send_scan_byte(3'd3, 8'h33);
    endtask

    task automatic test_both_phases();
        send_scan_byte(3'd4, 8'h03);
        send_scan_byte(3'd4, 8'h0C);
        send_scan_byte(3'd4, 8'h03);
    endtask

    task automatic test_extremes();
        send_scan_byte(3'd7, 8'hFF);
        send_scan_byte(3'd7, 8'h00);
        send_scan_byte(3'd0, 8'hFF);
        send_scan_byte(3'd0, 8'h00);
    endtask

    task automatic test_random_scan(input int n);
        logic [2:0] pos;
        logic [3:0] lo;
        logic [3:0] hi;
        for (int i = 0; i < n; i++)
        begin
            pos = 3'($urandom_range(0, 7));
            lo  = next_nibble(int'({pos, 1'b0}));
            hi  = next_nibble(int'({pos, 1'b1}));
            send_scan_byte(pos, {hi, lo});
        end
    endtask

    task automatic test_noise(input int n);
        for (int i = 0; i < n; i++)
            send_scan_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_backpressure();
        // results held off while the sender keeps requests coming
        idle_on = 1'b0;
        long_hold_req = 150;
        test_random_scan(40);
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        test_random_scan(30);
        wait_drained();
        test_random_scan(30);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_nibbles();
        test_button_changes();
        test_rotation();
        test_both_phases();
        test_extremes();
        test_backpressure();
        test_drain_pause();
        for (int seg = 0; seg < 7; seg++)
        begin
            idle_on = (seg % 3 != 2);
            test_random_scan(200);
        end
        idle_on = 1'b1;
        test_noise(250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && encoder_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
sv/mequad_pkg.sv
sv/mequad_front.sv
sv/mequad_queue.sv
sv/mequad_back.sv
sv/multi_encoder_quadrature_scanner.sv
bench/tb_multi_encoder_quadrature_scanner.sv
